// ----- hw/rtl/dqhr_pkg.sv -----
// Shared types and constants for the deque with half rotate.
// No dependencies; imported by every other file of the block.
package dqhr_pkg;

    localparam int DQHR_DEPTH = 64;
    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 7;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SWAP       = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t                     func;
        logic signed [WORD_W-1:0]  value;
    } op_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped;
        status_t                   status;
        logic [SIZE_W-1:0]         size;
    } result_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_ROT,
        S_ROT_LAST,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        K_DONE,
        K_POP,
        K_ROT
    } kind_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic rot_step;
        logic rot_flush;
        logic resp_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  rot_last;
    } dp_stat_t;

endpackage

// ----- hw/rtl/dqhr_ctrl.sv -----
// Sequencing state machine for the deque with half rotate.
// Depends on dqhr_pkg; drives the datapath through ctrl_cmd_t.
module dqhr_ctrl
    import dqhr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    output logic      result_valid,
    input  logic      result_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;

    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.kind)
                    K_POP:   state_next = S_POP_WAIT;
                    K_ROT:   state_next = S_ROT;
                    default: state_next = S_RESP;
                endcase
            end
            S_POP_WAIT:
            begin
                state_next = S_RESP;
            end
            S_ROT:
            begin
                if (stat.rot_last)
                begin
                    state_next = S_ROT_LAST;
                end
            end
            S_ROT_LAST:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        op_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                op_stall   = 1'b0;
                cmd.accept = op_valid;
            end
            S_EXEC:     cmd.exec      = 1'b1;
            S_ROT:      cmd.rot_step  = 1'b1;
            S_ROT_LAST: cmd.rot_flush = 1'b1;
            S_RESP:     cmd.resp_load = out_free;
            default:    cmd           = '0;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.resp_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |-> !(result_valid_reg && result_stall))
        else $error("result overwritten while stalled");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |=> result_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// ----- hw/rtl/dqhr_dp.sv -----
// Datapath of the deque with half rotate: ring store, pointers, count, result register.
// Depends on dqhr_pkg; commanded by dqhr_ctrl.
module dqhr_dp
    import dqhr_pkg::*;
#(
    parameter int DEPTH = DQHR_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    input  op_item_t     op,
    output dp_stat_t     stat,
    output result_item_t result
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

    function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        begin
            d = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
            return d[PW-1:0];
        end
    endfunction

    logic [WORD_W-1:0]        mem [DEPTH];
    logic [WORD_W-1:0]        rd_data_reg;

    op_item_t                 op_reg;
    logic [PW-1:0]            front_reg,  front_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [PW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]            remain_reg, remain_next;
    logic                     wr_pend_reg, wr_pend_next;
    status_t                  status_reg, status_next;
    logic                     pop_ok_reg, pop_ok_next;
    result_item_t             result_reg;

    logic                     mem_we;
    logic [PW-1:0]            mem_wa;
    logic [WORD_W-1:0]        mem_wd;
    logic                     mem_re;
    logic [PW-1:0]            mem_ra;

    logic                     is_full;
    logic                     is_empty;
    logic [PW-1:0]            tail_pos;
    logic [PW-1:0]            back_pos;
    logic [PW-1:0]            front_dec;
    logic [PW-1:0]            front_inc;
    logic [PW-1:0]            front_rot;
    logic [PW-1:0]            rd_ptr_inc;
    logic [PW-1:0]            wr_ptr_inc;

    assign is_full    = (count_reg >= CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign tail_pos   = wrap(SW'(front_reg) + SW'(count_reg));
    assign back_pos   = wrap(SW'(front_reg) + SW'(count_reg) - SW'(1));
    assign front_dec  = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;
    assign front_inc  = (front_reg == LAST_POS) ? '0 : front_reg + 1'b1;
    assign front_rot  = wrap(SW'(front_reg) + SW'(count_reg >> 1));
    assign rd_ptr_inc = (rd_ptr_reg == LAST_POS) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == LAST_POS) ? '0 : wr_ptr_reg + 1'b1;

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        remain_next  = remain_reg;
        wr_pend_next = wr_pend_reg;
        status_next  = status_reg;
        pop_ok_next  = pop_ok_reg;
        mem_we       = 1'b0;
        mem_wa       = wr_ptr_reg;
        mem_wd       = rd_data_reg;
        mem_re       = 1'b0;
        mem_ra       = rd_ptr_reg;
        stat.kind    = K_DONE;
        stat.rot_last = (remain_reg == CW'(1));

        if (cmd.exec)
        begin
            status_next  = ST_OK;
            pop_ok_next  = 1'b0;
            wr_pend_next = 1'b0;
            case (op_reg.func) inside
                FN_PUSH_FRONT, FN_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = op_reg.value;
                        count_next = count_reg + 1'b1;
                        if (op_reg.func == FN_PUSH_FRONT)
                        begin
                            mem_wa     = front_dec;
                            front_next = front_dec;
                        end
                        else
                        begin
                            mem_wa = tail_pos;
                        end
                    end
                end
                FN_POP_FRONT, FN_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        pop_ok_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                        stat.kind   = K_POP;
                        if (op_reg.func == FN_POP_FRONT)
                        begin
                            mem_ra     = front_reg;
                            front_next = front_inc;
                        end
                        else
                        begin
                            mem_ra = back_pos;
                        end
                    end
                end
                FN_SWAP:
                begin
                    if (count_reg >= CW'(2))
                    begin
                        rd_ptr_next = front_reg;
                        wr_ptr_next = tail_pos;
                        remain_next = count_reg >> 1;
                        front_next  = front_rot;
                        stat.kind   = K_ROT;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (cmd.rot_step)
        begin
            mem_re       = 1'b1;
            mem_ra       = rd_ptr_reg;
            rd_ptr_next  = rd_ptr_inc;
            remain_next  = remain_reg - 1'b1;
            wr_pend_next = 1'b1;
            if (wr_pend_reg)
            begin
                mem_we      = 1'b1;
                wr_ptr_next = wr_ptr_inc;
            end
        end

        if (cmd.rot_flush)
        begin
            mem_we       = 1'b1;
            wr_ptr_next  = wr_ptr_inc;
            wr_pend_next = 1'b0;
        end
    end

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= op;
        end
        if (cmd.resp_load)
        begin
            result_reg.popped <= pop_ok_reg ? rd_data_reg : '0;
            result_reg.status <= status_reg;
            result_reg.size   <= SIZE_W'(count_reg);
        end
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        remain_reg <= remain_next;
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            front_reg   <= front_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= LAST_POS)
        else $error("front pointer out of range");

    a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_flush |-> wr_pend_reg)
        else $error("rotate flush with no word in flight");
`endif

endmodule

// ----- hw/rtl/deque_with_half_rotate.sv -----
// Deque with half rotate: top level joining controller and datapath.
// Push beats pass through EXEC to RESP; pops add POP_WAIT for the registered store read;
// swap halves runs ROT steps, then ROT_LAST; with under two words held it goes to RESP.
// One beat in work at a time: next accept in the cycle after the result loads;
// the next beat is accepted while a result waits. Async active-low reset empties the deque.
module deque_with_half_rotate
    import dqhr_pkg::*;
#(
    parameter int DEPTH = DQHR_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    output logic         op_stall,
    input  op_item_t     op,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    dqhr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_stall     (op_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    dqhr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op     (op),
        .stat   (stat),
        .result (result)
    );

endmodule
